FILE: rtl/btpc_pkg.sv
// shared types and constants for the barometer compensation core
`default_nettype none
package btpc_pkg;
	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic signed [31:0] fine_temperature;
		logic        [31:0] pressure_pa;
		logic               pressure_invalid;
	} out_item_t;

	localparam int unsigned DivBits = 32;

	localparam logic [1:0] REG_TEMP = 2'd0;
	localparam logic [1:0] REG_PLOW = 2'd1;
	localparam logic [1:0] REG_PMID = 2'd2;
	localparam logic [1:0] REG_PHIGH = 2'd3;

	localparam logic [31:0] OFFS_64000 = 32'd64000;
	localparam logic [31:0] OFFS_32768 = 32'd32768;
	localparam logic [31:0] OFFS_2_20 = 32'd1048576;
	localparam logic [31:0] SCALE_3125 = 32'd3125;
	localparam logic [31:0] ROUND_128 = 32'd128;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction
endpackage
`default_nettype wire

FILE: rtl/btpc_div.sv
// pipelined 32-bit unsigned divider, one quotient bit per stage
`default_nettype none
module btpc_div
	import btpc_pkg::*;
#(
	parameter type tag_t = logic
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	input  wire tag_t        in_tag,
	output logic             out_valid,
	output logic [31:0]      quotient,
	output tag_t             out_tag
);
	logic               vld_q [DivBits];
	logic [31:0]        rem_q [DivBits];
	logic [31:0]        quo_q [DivBits];
	logic [31:0]        dvs_q [DivBits];
	tag_t               tag_q [DivBits];

	for (genvar i = 0; i < DivBits; i++) begin : g_st
		logic        vld_i;
		logic [31:0] rem_i, quo_i, dvs_i;
		tag_t        tag_i;
		logic [32:0] trial;
		logic [32:0] diff;
		if (i == 0) begin : g_first
			assign vld_i = in_valid;
			assign rem_i = '0;
			assign quo_i = dividend;
			assign dvs_i = divisor;
			assign tag_i = in_tag;
		end else begin : g_next
			assign vld_i = vld_q[i-1];
			assign rem_i = rem_q[i-1];
			assign quo_i = quo_q[i-1];
			assign dvs_i = dvs_q[i-1];
			assign tag_i = tag_q[i-1];
		end
		assign trial = {rem_i, quo_i[31]};
		assign diff  = trial - {1'b0, dvs_i};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en) begin
				vld_q[i] <= vld_i;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= diff[32] ? trial[31:0] : diff[31:0];
				quo_q[i] <= {quo_i[30:0], ~diff[32]};
				dvs_q[i] <= dvs_i;
				tag_q[i] <= tag_i;
			end
		end
	end

	assign out_valid = vld_q[DivBits-1];
	assign quotient  = quo_q[DivBits-1];
	assign out_tag   = tag_q[DivBits-1];
endmodule
`default_nettype wire

FILE: rtl/baro_temp_pressure_compensation_core.sv
// top level of the barometer temperature and pressure compensation core
// usage:
//  - input channel in_valid/in_stall carries one raw pressure and temperature pair
//  - output channel out_valid/out_stall carries temperature, fine temperature,
//    pressure and an invalid flag (zero divisor forces pressure to 0)
//  - coefficients are written over the apb port while the core is idle
// throughput: one transfer per cycle while in_stall is low
// the path from input transfer to output valid runs through the
//   six arithmetic stages, the 32-stage bit-per-stage divider and three
//   correction stages
// reset clears all valid bits and coefficients to zero
// out_stall holds the output register; a skid register catches the next
//   result, and only when it is full does the whole pipeline freeze
// in_stall comes straight from the skid register, so it rises the cycle
//   after a second result meets a held one and has no path from out_stall
`default_nettype none
module baro_temp_pressure_compensation_core
	import btpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data
);
	logic [47:0] tc_q, pl_q, pm_q, ph_q;
	logic [1:0]  ridx;
	assign ridx   = paddr[4:3];
	assign pready = 1'b1;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0; pl_q <= '0; pm_q <= '0; ph_q <= '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			case (ridx)
				REG_TEMP:  tc_q <= pwdata[47:0];
				REG_PLOW:  pl_q <= pwdata[47:0];
				REG_PMID:  pm_q <= pwdata[47:0];
				REG_PHIGH: ph_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_TEMP:  prdata = {16'd0, tc_q};
			REG_PLOW:  prdata = {16'd0, pl_q};
			REG_PMID:  prdata = {16'd0, pm_q};
			REG_PHIGH: prdata = {16'd0, ph_q};
			default:   prdata = '0;
		endcase
	end

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'd0, tc_q[15:0]};
	assign t2 = sx16(tc_q[31:16]);
	assign t3 = sx16(tc_q[47:32]);
	assign p1 = {16'd0, pl_q[15:0]};
	assign p2 = sx16(pl_q[31:16]);
	assign p3 = sx16(pl_q[47:32]);
	assign p4 = sx16(pm_q[15:0]);
	assign p5 = sx16(pm_q[31:16]);
	assign p6 = sx16(pm_q[47:32]);
	assign p7 = sx16(ph_q[15:0]);
	assign p8 = sx16(ph_q[31:16]);
	assign p9 = sx16(ph_q[47:32]);

	// global enable: pipeline advances unless the skid register is full
	logic en;
	logic sk_v_q;
	assign en       = !sk_v_q;
	assign in_stall = sk_v_q;

	logic acc;
	assign acc = in_valid && en;

	// stage 1: temperature products
	logic        v_s1;
	logic [31:0] up_s1, ta_s1, dd_s1;
	logic [31:0] ut32, dt;
	assign ut32 = {12'd0, in_data.raw_temperature};
	assign dt   = (ut32 >> 4) - t1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			up_s1 <= {12'd0, in_data.raw_pressure};
			ta_s1 <= ((ut32 >> 3) - (t1 << 1)) * t2;
			dd_s1 <= dt * dt;
		end
	end

	// stage 2: fine temperature pieces
	logic        v_s2;
	logic [31:0] up_s2, ta_s2, tb_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			up_s2 <= up_s1;
			ta_s2 <= asr(ta_s1, 11);
			tb_s2 <= asr(dd_s1, 12) * t3;
		end
	end

	// stage 3: fine temperature, centi-degrees, first pressure products
	logic        v_s3;
	logic [31:0] up_s3, tf_s3, tc_s3, a_s3, qq_s3;
	logic [31:0] tf, a0, q0;
	assign tf = ta_s2 + asr(tb_s2, 14);
	assign a0 = asr(tf, 1) - OFFS_64000;
	assign q0 = asr(a0, 2);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			up_s3 <= up_s2;
			tf_s3 <= tf;
			tc_s3 <= asr(tf * 32'd5 + ROUND_128, 8);
			a_s3  <= a0;
			qq_s3 <= q0 * q0;
		end
	end

	// stage 4: coefficient products
	logic        v_s4;
	logic [31:0] up_s4, tf_s4, tc_s4, b6_s4, b5_s4, x3_s4, x2_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			up_s4 <= up_s3; tf_s4 <= tf_s3; tc_s4 <= tc_s3;
			b6_s4 <= asr(qq_s3, 11) * p6;
			b5_s4 <= (a_s3 * p5) << 1;
			x3_s4 <= p3 * asr(qq_s3, 13);
			x2_s4 <= p2 * a_s3;
		end
	end

	// stage 5: divisor product and numerator offset
	logic        v_s5;
	logic [31:0] up_s5, tf_s5, tc_s5, dv_s5, b_s5;
	logic [31:0] x18;
	assign x18 = asr(asr(x3_s4, 3) + asr(x2_s4, 1), 18);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			up_s5 <= up_s4; tf_s5 <= tf_s4; tc_s5 <= tc_s4;
			dv_s5 <= (OFFS_32768 + x18) * p1;
			b_s5  <= asr(b6_s4 + b5_s4, 2) + (p4 << 16);
		end
	end

	// stage 6: numerator and divisor
	logic        v_s6;
	logic [31:0] tf_s6, tc_s6, num_s6, dv_s6;
	logic        big_s6;
	logic [31:0] num;
	assign num = ((OFFS_2_20 - up_s5) - asr(b_s5, 12)) * SCALE_3125;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tf_s6  <= tf_s5; tc_s6 <= tc_s5;
			dv_s6  <= asr(dv_s5, 15);
			big_s6 <= num[31];
			num_s6 <= num[31] ? num : (num << 1);
		end
	end

	typedef struct packed {
		logic [31:0] tf;
		logic [31:0] tc;
		logic        big;
		logic        zero;
	} dtag_t;

	dtag_t dtag_in, dtag_out;
	logic  dv_v;
	logic [31:0] dq;
	assign dtag_in = '{tf: tf_s6, tc: tc_s6, big: big_s6, zero: dv_s6 == '0};

	btpc_div #(.tag_t(dtag_t)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s6), .dividend(num_s6), .divisor(dv_s6), .in_tag(dtag_in),
		.out_valid(dv_v), .quotient(dq), .out_tag(dtag_out)
	);

	// stage 7: quotient and correction products
	logic        v_s7;
	dtag_t       t_s7;
	logic [31:0] p_s7, sq_s7, c8_s7;
	logic [31:0] pq, p3r;
	assign pq  = dtag_out.big ? (dq << 1) : dq;
	assign p3r = pq >> 3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= dv_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s7  <= dtag_out;
			p_s7  <= pq;
			sq_s7 <= p3r * p3r;
			c8_s7 <= (pq >> 2) * p8;
		end
	end

	// stage 8: p9 product
	logic        v_s8;
	dtag_t       t_s8;
	logic [31:0] p_s8, c9_s8, c8_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s8  <= t_s7; p_s8 <= p_s7;
			c9_s8 <= p9 * (sq_s7 >> 13);
			c8_s8 <= asr(c8_s7, 13);
		end
	end

	// stage 9: output register with skid register behind it
	logic [31:0] pf;
	out_item_t   res;
	out_item_t   sk_q;
	assign pf = p_s8 + asr(asr(c9_s8, 12) + c8_s8 + p7, 4);
	assign res.temperature_centi = t_s8.tc;
	assign res.fine_temperature  = t_s8.tf;
	assign res.pressure_pa       = t_s8.zero ? 32'd0 : pf;
	assign res.pressure_invalid  = t_s8.zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			sk_v_q    <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			// skid content goes first; the pipe is frozen while it is full
			out_valid <= sk_v_q ? 1'b1 : v_s8;
			sk_v_q    <= 1'b0;
		end else if (!sk_v_q) begin
			sk_v_q <= v_s8;
		end
	end
	always_ff @(posedge clk) begin
		if (!out_valid || !out_stall) begin
			out_data <= sk_v_q ? sk_q : res;
		end else if (!sk_v_q) begin
			sk_q <= res;
		end
	end

	// a zero divisor always reports zero pressure
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pressure_invalid |-> out_data.pressure_pa == '0)
		else $error("invalid result with nonzero pressure");
	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// input stall only while a result is held at the output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled without cause");
endmodule
`default_nettype wire

FILE: sim/baro_temp_pressure_compensation_core_test.sv
// testbench for the barometer compensation core: random samples checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module baro_temp_pressure_compensation_core_test;
	import btpc_pkg::*;

	// compensation predictor and queue of pending results
	class comp_scoreboard;
		logic [47:0] coef [4];
		out_item_t pending_results [$];
		int errors;

		function automatic logic [31:0] sar(input logic [31:0] x, input int n);
			return 32'($signed(x) >>> n);
		endfunction

		function automatic logic [31:0] s16(input logic [47:0] r, input int pos);
			logic [15:0] v;
			v = r[pos +: 16];
			return {{16{v[15]}}, v};
		endfunction

		function automatic out_item_t compensate(input in_item_t it);
			out_item_t o;
			logic [31:0] up, ut, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
			logic [31:0] a, b, d, tf, q, p;
			up = {12'd0, it.raw_pressure};
			ut = {12'd0, it.raw_temperature};
			t1 = {16'd0, coef[REG_TEMP][15:0]};
			t2 = s16(coef[REG_TEMP], 16);
			t3 = s16(coef[REG_TEMP], 32);
			p1 = {16'd0, coef[REG_PLOW][15:0]};
			p2 = s16(coef[REG_PLOW], 16);
			p3 = s16(coef[REG_PLOW], 32);
			p4 = s16(coef[REG_PMID], 0);
			p5 = s16(coef[REG_PMID], 16);
			p6 = s16(coef[REG_PMID], 32);
			p7 = s16(coef[REG_PHIGH], 0);
			p8 = s16(coef[REG_PHIGH], 16);
			p9 = s16(coef[REG_PHIGH], 32);
			// fine temperature and centidegrees
			a = sar(((ut >> 3) - (t1 << 1)) * t2, 11);
			d = (ut >> 4) - t1;
			b = sar(sar(d * d, 12) * t3, 14);
			tf = a + b;
			o.temperature_centi = sar(tf * 32'd5 + 32'd128, 8);
			o.fine_temperature = tf;
			// pressure
			a = sar(tf, 1) - 32'd64000;
			q = sar(a, 2);
			b = sar(q * q, 11) * p6;
			b = b + ((a * p5) << 1);
			b = sar(b, 2) + (p4 << 16);
			a = sar(sar(p3 * sar(q * q, 13), 3) + sar(p2 * a, 1), 18);
			a = sar((32'd32768 + a) * p1, 15);
			p = ((32'd1048576 - up) - sar(b, 12)) * 32'd3125;
			o.pressure_invalid = (a == 0);
			if (a == 0)
				p = 0;
			else begin
				// large dividend divides first
				if (p < 32'h8000_0000)
					p = (p << 1) / a;
				else
					p = (p / a) * 32'd2;
				a = sar(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
				b = sar((p >> 2) * p8, 13);
				p = p + sar(a + b + p7, 4);
			end
			o.pressure_pa = p;
			return o;
		endfunction

		function void note_sample(input in_item_t it);
			pending_results.push_back(compensate(it));
		endfunction

		function void check_result(input out_item_t got);
			out_item_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (got.temperature_centi !== e.temperature_centi) begin
				$error("temperature_centi exp %0d got %0d", e.temperature_centi,
					got.temperature_centi);
				errors++;
			end
			if (got.fine_temperature !== e.fine_temperature) begin
				$error("fine_temperature exp %0d got %0d", e.fine_temperature,
					got.fine_temperature);
				errors++;
			end
			if (got.pressure_pa !== e.pressure_pa) begin
				$error("pressure_pa exp %0d got %0d", e.pressure_pa, got.pressure_pa);
				errors++;
			end
			if (got.pressure_invalid !== e.pressure_invalid) begin
				$error("pressure_invalid exp %0b got %0b", e.pressure_invalid,
					got.pressure_invalid);
				errors++;
			end
		endfunction
	endclass

	localparam int Latency = 41;
	localparam int StallLimit = 20000;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [63:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, out_valid, out_stall;
	in_item_t in_data;
	out_item_t out_data;

	comp_scoreboard sb;
	bit stim_done;
	bit hold_output;	// long receiver hold-off requested by the sender
	int idle_cycles;

	baro_temp_pressure_compensation_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// two-phase register write, only while the core is idle
	task automatic write_coeffs(input logic [1:0] idx, input logic [47:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'b000};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.coef[idx] = val;
		@(posedge clk);
	endtask

	// wait for every pending result, then let the pipe drain
	task automatic drain();
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	// one sample transfer, optional gap before it
	task automatic send_sample(input in_item_t it, input int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_sample(it);
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	// realistic coefficient set with random content
	function automatic logic [47:0] typical(input logic [1:0] idx);
		logic [15:0] w0, w1, w2;
		w0 = 16'($urandom_range(1, 65535));
		w1 = 16'($urandom);
		w2 = 16'($urandom);
		if (idx == REG_TEMP) begin
			w0 = 16'($urandom_range(26000, 29000));
			w1 = 16'($urandom_range(26000, 27500));
			w2 = 16'($urandom_range(0, 2000)) - 16'd1000;
		end
		if (idx == REG_PLOW) w0 = 16'($urandom_range(30000, 40000));
		return {w2, w1, w0};
	endfunction

	task automatic end_sending();
		in_valid <= 0;
	endtask

	task automatic random_phase(input int n, input int kind);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it.raw_pressure = 20'($urandom);
			it.raw_temperature = 20'($urandom);
			if (kind == 0 && $urandom_range(0, 3) != 0) begin
				it.raw_pressure = 20'($urandom_range(300000, 700000));
				it.raw_temperature = 20'($urandom_range(450000, 600000));
			end
			send_sample(it, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
		end
	endtask

	// stimulus
	initial begin
		in_item_t it;
		logic [47:0] ext [4];
		sb = new();
		sb.errors = 0;
		for (int r = 0; r < 4; r++) sb.coef[r] = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; in_data = '0;
		stim_done = 0;
		hold_output = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset coefficients: divisor zero path
		it = '0;
		send_sample(it, 0);
		it = '1;
		send_sample(it, 0);
		in_valid <= 0;
		drain();
		// extremes of every register
		ext[0] = '1; ext[1] = 48'h8000_8000_FFFF; ext[2] = 48'h7FFF_7FFF_7FFF;
		ext[3] = 48'h8000_8000_8000;
		for (int r = 0; r < 4; r++) write_coeffs(2'(r), ext[r]);
		it.raw_pressure = 0; it.raw_temperature = '1;
		send_sample(it, 0);
		it.raw_pressure = '1; it.raw_temperature = 0;
		send_sample(it, 0);
		in_valid <= 0;
		drain();
		// typical set: both division paths and sample extremes
		for (int r = 0; r < 4; r++) write_coeffs(2'(r), typical(2'(r)));
		for (int i = 0; i < 16; i++) begin
			it.raw_pressure = (i[0]) ? 20'hFFFFF : (i[1] ? 20'd0 : 20'($urandom));
			it.raw_temperature = (i[2]) ? 20'hFFFFF : (i[3] ? 20'd0 : 20'($urandom));
			send_sample(it, 0);
		end
		in_valid <= 0;
		drain();
		// random phases over several coefficient settings
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < 4; r++)
				write_coeffs(2'(r), (ph % 3 == 2) ? rand48() : typical(2'(r)));
			if (ph == 3) begin
				// long receiver hold-off while the sender keeps offering
				hold_output = 1;
				random_phase(60, 0);
				hold_output = 0;
			end
			random_phase(150, ph % 3 == 2);
			end_sending();
			// sender pauses until every result is back
			drain();
		end
		for (int r = 0; r < 4; r++) write_coeffs(2'(r), 48'd0);
		random_phase(20, 1);
		end_sending();
		drain();
		stim_done = 1;
	end

	// receiver: random stall per item, plus the long hold-off
	initial begin
		int wait_n;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			if (wait_n > 0 || hold_output) begin
				out_stall <= 1;
				repeat (wait_n) @(posedge clk);
				if (hold_output) begin
					repeat (300) @(posedge clk);
				end
			end
			out_stall <= 0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// result checking, sampled on the edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (stim_done) begin
			if (sb.errors == 0 && sb.pending_results.size() == 0)
				$display("status: pass");
			else
				$display("status: fail");
			$finish;
		end else if (idle_cycles > StallLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial idle_cycles = 0;
endmodule
`default_nettype wire
